// File: rtl/timestamp_calendar_truncate_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp calendar truncation block
// Clocked concurrent assertions, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_CALENDAR_TRUNCATE_MACROS_SVH
`define TIMESTAMP_CALENDAR_TRUNCATE_MACROS_SVH

// property checked outside of reset
`define TSCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property checked on every edge, reset included
`define TSCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tsct_pkg.sv
// ----------------------------------------------------------------------------
// tsct_pkg
// Widths, calendar constants, unit codes and pipeline record for the
// timestamp calendar truncation block.
// ----------------------------------------------------------------------------
package tsct_pkg;

   localparam int TS_W   = 38;
   localparam int UNIT_W = 3;
   localparam int DAYS_W = 22;  // day count since epoch, shifted by EPOCH_SHIFT too
   localparam int SOD_W  = 17;  // second of day
   localparam int ERA_W  = 5;
   localparam int DOE_W  = 18;  // day of era
   localparam int QC_W   = 7;   // day of era / 1460
   localparam int CB_W   = 3;   // day of era / 36524
   localparam int YOE_W  = 9;
   localparam int DOY_W  = 9;
   localparam int V_W    = 11;  // 5 * doy + 2
   localparam int MP_W   = 4;
   localparam int MIN_W  = 11;  // minute of day
   localparam int HOUR_W = 5;
   localparam int SECM_W = 6;   // second of minute
   localparam int SECH_W = 12;  // second of hour
   localparam int CENT_W = 2;

   localparam int SECS_PER_MIN  = 60;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_DAY  = 86400;
   localparam int DAY_SHIFT     = 7;    // 86400 = 128 * 675
   localparam int DAY_ODD       = SECS_PER_DAY >> DAY_SHIFT;
   localparam int MIN_SHIFT     = 2;    // 60 = 4 * 15
   localparam int MIN_ODD       = SECS_PER_MIN >> MIN_SHIFT;
   localparam int HOUR_SHIFT    = 4;    // 3600 = 16 * 225
   localparam int HOUR_ODD      = SECS_PER_HOUR >> HOUR_SHIFT;

   localparam int EPOCH_SHIFT   = 719468;
   localparam int DAYS_PER_ERA  = 146097;
   localparam int DAYS_PER_CENT = 36524;
   localparam int DAYS_PER_QUAD = 1460;
   localparam int DAYS_PER_YEAR = 365;
   localparam int MONTH_SPAN    = 153;  // days in five March-based months
   localparam int MP_JAN        = 10;   // January in March-based month index
   localparam int JAN_START     = 306;  // March-based day of year of Jan 1
   localparam int JAN_FEB_DAYS  = 59;

   localparam int NSTAGE = 12;

   typedef enum logic [UNIT_W-1:0] {
      UNIT_SECOND = 3'd0,
      UNIT_MINUTE = 3'd1,
      UNIT_HOUR   = 3'd2,
      UNIT_DAY    = 3'd3,
      UNIT_MONTH  = 3'd4,
      UNIT_YEAR   = 3'd5
   } unit_type;

   typedef struct packed {
      unit_type            unit;
      logic [TS_W-1:0]     t;
      logic [DAYS_W-1:0]   days;
      logic [DAYS_W-1:0]   z;
      logic [ERA_W-1:0]    era;
      logic [SOD_W-1:0]    sod;
      logic [DOE_W-1:0]    doe;
      logic [MIN_W-1:0]    qm;
      logic [HOUR_W-1:0]   qh;
      logic [QC_W-1:0]     qa;
      logic [CB_W-1:0]     qb;
      logic                qc;
      logic [SECM_W-1:0]   secm;
      logic [SECH_W-1:0]   sech;
      logic [DOE_W-1:0]    n;
      logic [TS_W-1:0]     tres;
      logic [YOE_W-1:0]    yoe;
      logic [DOE_W-1:0]    ys;
      logic                leap;
      logic [DOY_W-1:0]    doy;
      logic [V_W-1:0]      v;
      logic [MP_W-1:0]     mp;
      logic [DOY_W-1:0]    off;
      logic [DAYS_W-1:0]   rdays;
   } pipe_type;

   // March-based day of year on which month mp starts: (153 * mp + 2) / 5
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] d;
      case (mp)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/tsct_recip_div.sv
// ----------------------------------------------------------------------------
// tsct_recip_div
// Exact floor division of an unsigned value by a constant, done as one
// multiply by a rounded-up reciprocal and a shift.
// ----------------------------------------------------------------------------
module tsct_recip_div #(
   parameter int IN_W    = 16,
   parameter int DIVISOR = 3,
   parameter int OUT_W   = 16
) (
   input  logic [IN_W-1:0]  x,
   output logic [OUT_W-1:0] q
);

   localparam int L   = $clog2(DIVISOR);
   localparam int K   = IN_W + L;
   localparam int M_W = IN_W + 1;
   localparam int P_W = IN_W + M_W;
   localparam logic [63:0] MULT_FULL =
      ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

   logic [P_W-1:0] prod;

   assign prod = P_W'(x) * P_W'(MULT_FULL[M_W-1:0]);
   assign q    = OUT_W'(prod >> K);

endmodule

// File: rtl/timestamp_calendar_truncate.sv
// ----------------------------------------------------------------------------
// timestamp_calendar_truncate: UTC calendar truncation of Unix seconds
// The input register, 11 compute stages and the output register lie between an
// accepted beat and rsp_valid. Throughput: one beat per cycle while req_ready is high.
// req_ready drops only while two finished results wait at the output.
// Reset is synchronous and clears the valid bits only; data is not reset.
// ----------------------------------------------------------------------------
module timestamp_calendar_truncate
   import tsct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TS_W-1:0]   req_timestamp,
   input  logic [UNIT_W-1:0] req_unit,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [TS_W-1:0]   rsp_truncated_time
);

   localparam int MUL_W = DAYS_W + SOD_W;

   logic [NSTAGE-1:0] vld_ff, vld_in;
   pipe_type          pipe_ff [NSTAGE];
   pipe_type          pipe_in [NSTAGE];

   logic              en;
   logic              push;
   logic              pop;
   logic              out_vld_ff, out_vld_in;
   logic [TS_W-1:0]   out_data_ff, out_data_in;
   logic              skid_vld_ff, skid_vld_in;
   logic [TS_W-1:0]   skid_data_ff, skid_data_in;
   logic [TS_W-1:0]   res_c;

   logic [DAYS_W-1:0] days_q;
   logic [DAYS_W-1:0] z_c;
   logic [ERA_W-1:0]  era_q;
   logic [MUL_W-1:0]  dsec_c;
   logic [MIN_W-1:0]  qm_q;
   logic [HOUR_W-1:0] qh_q;
   logic [QC_W-1:0]   qa_q;
   logic [YOE_W-1:0]  yoe_q;
   logic [MP_W-1:0]   mp_q;
   logic [MUL_W-1:0]  cal_c;
   logic [CENT_W-1:0] cent_c;

   // constant dividers
   tsct_recip_div #(.IN_W(TS_W - DAY_SHIFT), .DIVISOR(DAY_ODD), .OUT_W(DAYS_W)) u_div_day (
      .x (pipe_ff[0].t[TS_W-1:DAY_SHIFT]),
      .q (days_q)
   );

   assign z_c = pipe_ff[1].days + DAYS_W'(EPOCH_SHIFT);

   tsct_recip_div #(.IN_W(DAYS_W), .DIVISOR(DAYS_PER_ERA), .OUT_W(ERA_W)) u_div_era (
      .x (z_c),
      .q (era_q)
   );

   tsct_recip_div #(.IN_W(SOD_W - MIN_SHIFT), .DIVISOR(MIN_ODD), .OUT_W(MIN_W)) u_div_min (
      .x (pipe_ff[2].sod[SOD_W-1:MIN_SHIFT]),
      .q (qm_q)
   );

   tsct_recip_div #(.IN_W(SOD_W - HOUR_SHIFT), .DIVISOR(HOUR_ODD), .OUT_W(HOUR_W)) u_div_hour (
      .x (pipe_ff[2].sod[SOD_W-1:HOUR_SHIFT]),
      .q (qh_q)
   );

   tsct_recip_div #(.IN_W(DOE_W), .DIVISOR(DAYS_PER_QUAD), .OUT_W(QC_W)) u_div_quad (
      .x (pipe_ff[3].doe),
      .q (qa_q)
   );

   tsct_recip_div #(.IN_W(DOE_W), .DIVISOR(DAYS_PER_YEAR), .OUT_W(YOE_W)) u_div_year (
      .x (pipe_ff[5].n),
      .q (yoe_q)
   );

   tsct_recip_div #(.IN_W(V_W), .DIVISOR(MONTH_SPAN), .OUT_W(MP_W)) u_div_month (
      .x (pipe_ff[8].v),
      .q (mp_q)
   );

   assign dsec_c = MUL_W'(pipe_ff[1].days) * MUL_W'(SECS_PER_DAY);
   assign cal_c  = MUL_W'(pipe_ff[11].rdays) * MUL_W'(SECS_PER_DAY);
   assign cent_c = CENT_W'(pipe_ff[6].yoe >= YOE_W'(100)) +
                   CENT_W'(pipe_ff[6].yoe >= YOE_W'(200)) +
                   CENT_W'(pipe_ff[6].yoe >= YOE_W'(300));

   // stage datapath
   always_comb begin
      // input register
      pipe_in[0]      = pipe_ff[0];
      pipe_in[0].unit = unit_type'(req_unit);
      pipe_in[0].t    = req_timestamp;

      // day number
      pipe_in[1]      = pipe_ff[0];
      pipe_in[1].days = days_q;

      // era, second of day
      pipe_in[2]      = pipe_ff[1];
      pipe_in[2].z    = z_c;
      pipe_in[2].era  = era_q;
      pipe_in[2].sod  = pipe_ff[1].t[SOD_W-1:0] - dsec_c[SOD_W-1:0];

      // day of era, minute and hour of day
      pipe_in[3]      = pipe_ff[2];
      pipe_in[3].doe  = DOE_W'(pipe_ff[2].z -
                               DAYS_W'(pipe_ff[2].era) * DAYS_W'(DAYS_PER_ERA));
      pipe_in[3].qm   = qm_q;
      pipe_in[3].qh   = qh_q;

      // leap corrections, second of minute and hour
      pipe_in[4]      = pipe_ff[3];
      pipe_in[4].qa   = qa_q;
      pipe_in[4].qb   = CB_W'(pipe_ff[3].doe >= DOE_W'(DAYS_PER_CENT)) +
                        CB_W'(pipe_ff[3].doe >= DOE_W'(2 * DAYS_PER_CENT)) +
                        CB_W'(pipe_ff[3].doe >= DOE_W'(3 * DAYS_PER_CENT)) +
                        CB_W'(pipe_ff[3].doe >= DOE_W'(4 * DAYS_PER_CENT));
      pipe_in[4].qc   = (pipe_ff[3].doe == DOE_W'(DAYS_PER_ERA - 1));
      pipe_in[4].secm = SECM_W'(pipe_ff[3].sod -
                                SOD_W'(pipe_ff[3].qm) * SOD_W'(SECS_PER_MIN));
      pipe_in[4].sech = SECH_W'(pipe_ff[3].sod -
                                SOD_W'(pipe_ff[3].qh) * SOD_W'(SECS_PER_HOUR));

      // year numerator, time-of-day result
      pipe_in[5]      = pipe_ff[4];
      pipe_in[5].n    = pipe_ff[4].doe - DOE_W'(pipe_ff[4].qa) +
                        DOE_W'(pipe_ff[4].qb) - DOE_W'(pipe_ff[4].qc);
      case (pipe_ff[4].unit)
         UNIT_MINUTE: pipe_in[5].tres = pipe_ff[4].t - TS_W'(pipe_ff[4].secm);
         UNIT_HOUR:   pipe_in[5].tres = pipe_ff[4].t - TS_W'(pipe_ff[4].sech);
         UNIT_DAY:    pipe_in[5].tres = pipe_ff[4].t - TS_W'(pipe_ff[4].sod);
         default:     pipe_in[5].tres = pipe_ff[4].t;
      endcase

      // year of era
      pipe_in[6]      = pipe_ff[5];
      pipe_in[6].yoe  = yoe_q;

      // days before the March-based year
      pipe_in[7]      = pipe_ff[6];
      pipe_in[7].ys   = DOE_W'(pipe_ff[6].yoe) * DOE_W'(DAYS_PER_YEAR) +
                        DOE_W'(pipe_ff[6].yoe >> 2) - DOE_W'(cent_c);
      pipe_in[7].leap = (pipe_ff[6].yoe[1:0] == 2'd0) && (cent_c == 2'd0 ||
                        pipe_ff[6].yoe == YOE_W'(0) ||
                        (pipe_ff[6].yoe != YOE_W'(100) &&
                         pipe_ff[6].yoe != YOE_W'(200) &&
                         pipe_ff[6].yoe != YOE_W'(300)));

      // day of year
      pipe_in[8]      = pipe_ff[7];
      pipe_in[8].doy  = DOY_W'(pipe_ff[7].doe - pipe_ff[7].ys);
      pipe_in[8].v    = V_W'({pipe_in[8].doy, 2'b00}) + V_W'(pipe_in[8].doy) + V_W'(2);

      // month
      pipe_in[9]      = pipe_ff[8];
      pipe_in[9].mp   = mp_q;

      // days back to the period start
      pipe_in[10]     = pipe_ff[9];
      if (pipe_ff[9].unit == UNIT_MONTH) begin
         pipe_in[10].off = pipe_ff[9].doy - month_start(pipe_ff[9].mp);
      end else if (pipe_ff[9].mp >= MP_W'(MP_JAN)) begin
         pipe_in[10].off = pipe_ff[9].doy - DOY_W'(JAN_START);
      end else begin
         pipe_in[10].off = pipe_ff[9].doy + DOY_W'(JAN_FEB_DAYS) +
                           DOY_W'(pipe_ff[9].leap);
      end

      // period start day
      pipe_in[11]       = pipe_ff[10];
      pipe_in[11].rdays = pipe_ff[10].days - DAYS_W'(pipe_ff[10].off);
   end

   always_comb begin
      if (pipe_ff[11].unit inside {UNIT_SECOND, UNIT_MINUTE, UNIT_HOUR, UNIT_DAY}) begin
         res_c = pipe_ff[11].tres;
      end else begin
         res_c = cal_c[TS_W-1:0];
      end
   end

   // pipeline advances while the skid register is free
   assign en        = !skid_vld_ff;
   assign req_ready = en;
   assign vld_in    = {vld_ff[NSTAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NSTAGE; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // output register with skid
   always_comb begin
      push         = en && vld_ff[NSTAGE-1];
      pop          = out_vld_ff && rsp_ready;
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!out_vld_ff || pop) begin
            out_vld_in  = 1'b1;
            out_data_in = res_c;
         end else begin
            skid_vld_in  = 1'b1;
            skid_data_in = res_c;
         end
      end else if (pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_truncated_time = out_data_ff;

endmodule

// File: rtl/tsct_checker.sv
// ----------------------------------------------------------------------------
// tsct_checker
// Port-level checks on the timestamp calendar truncation block, bound to
// the top level.
// ----------------------------------------------------------------------------
`include "timestamp_calendar_truncate_macros.svh"

module tsct_checker
   import tsct_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [TS_W-1:0]   req_timestamp,
   input logic [UNIT_W-1:0] req_unit,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [TS_W-1:0]   rsp_truncated_time
);

   `TSCT_ASSERT(a_req_hold, clock, reset, req_valid && !req_ready |=> req_valid && $stable(req_timestamp) && $stable(req_unit), "req beat changed while stalled")
   `TSCT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped while stalled")
   `TSCT_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_truncated_time), "rsp beat changed while stalled")
   `TSCT_ASSERT(a_stall_when_full, clock, reset, !req_ready |-> rsp_valid, "req stalled with no result waiting")
   `TSCT_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> req_ready && !rsp_valid, "reset left a beat or a stall")

endmodule

bind timestamp_calendar_truncate tsct_checker u_tsct_checker (.*);

// File: tb/tb_timestamp_calendar_truncate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_calendar_truncate: self-checking bench for calendar truncation
// Sends timestamps with every unit code through the valid/ready request
// channel, predicts the UTC period start of each beat in a scoreboard and
// checks every response beat in order. Covers the first and last seconds of
// the range, values past year 9999, leap days and month and year edges, then
// random beats. Both sides idle at random, and the response side holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module tb_timestamp_calendar_truncate;
   import tsct_pkg::*;

   localparam logic [UNIT_W-1:0] UNIT_SPARE_6 = 3'd6;
   localparam logic [UNIT_W-1:0] UNIT_SPARE_7 = 3'd7;
   localparam logic [TS_W-1:0]   TS_LAST_9999 = 38'd253402300799;
   localparam logic [TS_W-1:0]   TS_ALL_ONES  = '1;
   localparam int N_RANDOM    = 1530;
   localparam int QUIET_TAIL  = 200;
   localparam int HOLD_AT     = 500;
   localparam int HOLD_CYCLES = 300;

   class trunc_scoreboard;
      logic [TS_W-1:0] floors_due[$];
      int beats_sent;
      int matched;
      int mismatches;
      int per_unit[8];

      // start of the UTC second, minute, hour, day, month or year holding ts; spare unit codes give the year
      function logic [TS_W-1:0] calendar_floor(logic [TS_W-1:0] ts,
                                               logic [UNIT_W-1:0] unit);
         bit [63:0] t, z, era, doe, yoe, doy, mp, mon, yr;
         bit [63:0] ya, era_a, yoe_a, mp_a, doy_a, doe_a, r;
         t = 64'(ts);
         case (unit)
            UNIT_SECOND: r = t;
            UNIT_MINUTE: r = t - t % 60;
            UNIT_HOUR:   r = t - t % 3600;
            UNIT_DAY:    r = t - t % 86400;
            default: begin
               z   = t / 86400 + 719468;
               era = z / 146097;
               doe = z - era * 146097;
               yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
               doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
               mp  = (5 * doy + 2) / 153;
               mon = (mp < 10) ? mp + 3 : mp - 9;
               yr  = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
               if (unit != UNIT_MONTH) mon = 1;
               ya    = (mon <= 2) ? yr - 1 : yr;
               era_a = ya / 400;
               yoe_a = ya - era_a * 400;
               mp_a  = (mon > 2) ? mon - 3 : mon + 9;
               doy_a = (153 * mp_a + 2) / 5;
               doe_a = yoe_a * 365 + yoe_a / 4 - yoe_a / 100 + doy_a;
               r     = (era_a * 146097 + doe_a - 719468) * 86400;
            end
         endcase
         return r[TS_W-1:0];
      endfunction

      function void note_request(logic [TS_W-1:0] ts, logic [UNIT_W-1:0] unit);
         floors_due.push_back(calendar_floor(ts, unit));
         beats_sent++;
         per_unit[unit]++;
      endfunction

      function void check_result(logic [TS_W-1:0] got);
         logic [TS_W-1:0] want;
         if (floors_due.size() == 0) begin
            $error("truncated_time: expected none, actual %0d", got);
            mismatches++;
            return;
         end
         want = floors_due.pop_front();
         if (got !== want) begin
            $error("truncated_time: expected %0d, actual %0d", want, got);
            mismatches++;
         end else begin
            matched++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [TS_W-1:0]   req_timestamp = '0;
   logic [UNIT_W-1:0] req_unit = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [TS_W-1:0]   rsp_truncated_time;

   bit quiet = 1'b0;
   bit hold_rsp = 1'b0;
   int hold_count = 0;

   trunc_scoreboard sb = new();

   timestamp_calendar_truncate DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_timestamp      (req_timestamp),
      .req_unit           (req_unit),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_truncated_time (rsp_truncated_time)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_truncated_time);
   end

   task automatic drive_beat(input logic [TS_W-1:0] ts, input logic [UNIT_W-1:0] unit);
      req_valid     <= 1'b1;
      req_timestamp <= ts;
      req_unit      <= unit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(ts, unit);
      @(negedge clock);
   endtask

   task automatic pause_req(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // half near day, month and year edges, some past year 9999
   function automatic logic [TS_W-1:0] random_stamp();
      logic [TS_W-1:0]   ts;
      logic [TS_W-1:0]   anchor;
      logic [UNIT_W-1:0] edge_unit;
      int pick;
      int offset;
      pick = $urandom_range(0, 99);
      ts = {6'($urandom_range(0, 58)), 32'($urandom)};
      if (ts > TS_LAST_9999) ts = ts - 38'd1000000000;
      if (pick < 10) begin
         ts = {6'($urandom_range(59, 63)), 32'($urandom)};
      end else if (pick < 15) begin
         ts = 38'($urandom_range(0, 400000000));
      end else if (pick < 65) begin
         case ($urandom_range(0, 2))
            0:       edge_unit = UNIT_DAY;
            1:       edge_unit = UNIT_MONTH;
            default: edge_unit = UNIT_YEAR;
         endcase
         anchor = sb.calendar_floor(ts, edge_unit);
         offset = $urandom_range(0, 6) - 3;
         ts = (anchor >= 3) ? 38'(longint'(anchor) + offset) : anchor;
      end
      return ts;
   endfunction

   initial begin : rsp_side
      int stall;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : req_side
      int i;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < 8; i++) drive_beat('0, 3'(i));
      drive_beat(TS_LAST_9999, UNIT_MONTH);
      drive_beat(TS_LAST_9999, UNIT_YEAR);
      drive_beat(TS_LAST_9999, UNIT_DAY);
      drive_beat(TS_LAST_9999, UNIT_HOUR);
      drive_beat(TS_LAST_9999, UNIT_MINUTE);
      drive_beat(TS_ALL_ONES, UNIT_SPARE_7);
      drive_beat(TS_ALL_ONES, UNIT_MONTH);
      drive_beat(TS_ALL_ONES, UNIT_SECOND);
      drive_beat(38'd951782400, UNIT_MONTH);   // 2000-02-29 00:00:00
      drive_beat(38'd951868799, UNIT_DAY);     // 2000-02-29 23:59:59
      drive_beat(38'd4107542399, UNIT_MONTH);  // 2100-02-28 23:59:59
      drive_beat(38'd4107542400, UNIT_SPARE_6);
      drive_beat(38'd946684799, UNIT_YEAR);    // 1999-12-31 23:59:59
      drive_beat(38'd59, UNIT_MINUTE);
      drive_beat(38'd60, UNIT_MINUTE);

      for (i = 0; i < N_RANDOM; i++) begin
         if (i == HOLD_AT) hold_rsp = 1'b1;
         if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) pause_req($urandom_range(1, 12));
         drive_beat(random_stamp(), 3'($urandom_range(0, 7)));
      end
      req_valid <= 1'b0;

      while (sb.floors_due.size() != 0) @(negedge clock);
      repeat (3 * NSTAGE) @(negedge clock);

      $display("Run: %0d beats in, %0d results matched, %0d mismatches",
               sb.beats_sent, sb.matched, sb.mismatches);
      $display("Beats per unit code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               sb.per_unit[0], sb.per_unit[1], sb.per_unit[2], sb.per_unit[3],
               sb.per_unit[4], sb.per_unit[5], sb.per_unit[6], sb.per_unit[7]);
      if (sb.mismatches == 0 && sb.floors_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
